@@ rtl/kls_alloc_pkg.sv @@
// Package for the keyed light slot allocator: table size, result codes,
// the slot entry layout and the sequencer states. No dependencies.

package kls_alloc_pkg;

  localparam int unsigned SLOTS       = 32;
  localparam int unsigned IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MAX_REPORTS = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_REPORTS + 1);

  // floor(x / 1000) == (x * RECIP_M) >> RECIP_SH for every x below 2**30.
  localparam int unsigned DIV_K    = 1000;
  localparam int unsigned RECIP_SH = 40;
  localparam logic [30:0] RECIP_M  = 31'd1099511628;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    HOW_KEY     = 2'd0,
    HOW_EXPIRED = 2'd1,
    HOW_FORCED  = 2'd2,
    HOW_TICK    = 2'd3
  } how_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_DECAY,
    ST_ALLOC_WR,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] die;
    logic [19:0] radius;
    logic [19:0] decay;
    logic        dark;
    logic        ent_only;
  } entry_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] key;
    logic [31:0] now;
    logic [31:0] die;
    logic [15:0] elapsed;
    logic [19:0] radius;
    logic [19:0] decay;
    logic        dark;
    logic        ent_only;
  } req_t;

endpackage

@@ rtl/keyed_light_slot_allocator.sv @@
// Keyed light slot allocator: a slot table in a memory with per-slot valid
// bits, a small sequencer and one shared multiplier for the tick decay.
// Depends on kls_alloc_pkg.
//
// An allocate reads and checks every slot, then writes the picked one; its
// result strobes in the first cycle that busy_o is low again. A tick reads and
// checks every slot and, for each live slot, multiplies, divides by the
// reciprocal and writes back; each report strobes once the next live slot has
// decayed, the last one in the first cycle that busy_o is low again. Each slot
// is read through a registered memory read before it is checked. One
// transaction at a time: start_i is taken only while busy_o is low. Reset clears
// the valid bits at once, so every slot reads as all zero.
module keyed_light_slot_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  kls_alloc_pkg::cmd_e       cmd_i,
  input  logic [15:0]               light_key_i,
  input  logic [31:0]               now_ms_i,
  input  logic [31:0]               die_ms_i,
  input  logic [15:0]               elapsed_ms_i,
  input  logic [19:0]               start_radius_i,
  input  logic [19:0]               decay_rate_i,
  input  logic                      dark_in_i,
  input  logic                      entities_only_in_i,
  output logic                      res_valid_o,
  output logic [4:0]                slot_o,
  output logic [1:0]                how_o,
  output logic [19:0]               radius_out_o,
  output logic                      dark_flag_o,
  output logic                      only_entities_flag_o,
  output logic                      last_o
);
  import kls_alloc_pkg::*;

  state_e state_q, state_d;

  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic             key_hit_q, exp_hit_q;
  logic [IDX_W-1:0] key_idx_q, exp_idx_q;
  req_t             req_q;

  entry_t           slot_mem_q [SLOTS];
  logic             slot_vld_q [SLOTS];
  entry_t           rd_q;
  logic             rd_vld_q;
  entry_t           cur_q;

  logic [35:0]      x_q;
  logic [19:0]      quot_q;
  logic             ge_q;

  logic [IDX_W-1:0] pend_idx_q;
  logic [19:0]      pend_rad_q;
  logic             pend_dark_q, pend_eo_q;

  logic             res_valid_q;
  logic [4:0]       out_slot_q;
  logic [1:0]       out_how_q;
  logic [19:0]      out_rad_q;
  logic             out_dark_q, out_eo_q, out_last_q;

  // Datapath signals.
  entry_t           eff;
  logic             live, last_idx, advance;
  logic [29:0]      mul_a;
  logic [30:0]      mul_b;
  logic [60:0]      mul_p;
  logic [29:0]      thresh;
  logic [19:0]      new_rad;
  logic [IDX_W-1:0] pick;
  how_e             pick_how;

  // Control from the output decoder.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             emit;
  logic [IDX_W-1:0] emit_idx;
  how_e             emit_how;
  logic [19:0]      emit_rad;
  logic             emit_dark, emit_eo, emit_last;
  logic [IDX_W+4:0] emit_ext;

  assign eff      = rd_vld_q ? rd_q : '0;
  assign live     = !(eff.die < req_q.now) && (eff.radius != 20'd0);
  assign last_idx = (idx_q == IDX_W'(SLOTS - 1));
  assign advance  = ((state_q == ST_CHECK) && !((req_q.cmd == CMD_TICK) && live))
                    || (state_q == ST_DECAY);

  // The one multiplier: elapsed * decay first, then the reciprocal of 1000.
  always_comb begin
    if (state_q == ST_MUL1) begin
      mul_a = 30'(cur_q.decay);
      mul_b = 31'(req_q.elapsed);
    end else begin
      mul_a = x_q[29:0];
      mul_b = RECIP_M;
    end
  end
  assign mul_p = 61'(mul_a) * 61'(mul_b);

  // The loss reaches the radius exactly when elapsed * decay >= 1000 * radius;
  // below that the product stays under 2**30, where the reciprocal is exact.
  assign thresh  = 30'(cur_q.radius) * 30'(DIV_K);
  assign new_rad = ge_q ? 20'd0 : (cur_q.radius - quot_q);

  always_comb begin
    if (key_hit_q) begin
      pick     = key_idx_q;
      pick_how = HOW_KEY;
    end else if (exp_hit_q) begin
      pick     = exp_idx_q;
      pick_how = HOW_EXPIRED;
    end else begin
      pick     = '0;
      pick_how = HOW_FORCED;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_CHECK;
      ST_CHECK: begin
        if ((req_q.cmd == CMD_TICK) && live) state_d = ST_MUL1;
        else if (!last_idx)                  state_d = ST_READ;
        else if (req_q.cmd == CMD_TICK)      state_d = ST_FLUSH;
        else                                 state_d = ST_ALLOC_WR;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DECAY;
      ST_DECAY: begin
        state_d = last_idx ? ST_FLUSH : ST_READ;
      end
      ST_ALLOC_WR: state_d = ST_IDLE;
      ST_FLUSH:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory writes and result emission.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = cur_q;
    emit      = 1'b0;
    emit_idx  = pend_idx_q;
    emit_how  = HOW_TICK;
    emit_rad  = pend_rad_q;
    emit_dark = pend_dark_q;
    emit_eo   = pend_eo_q;
    emit_last = 1'b0;
    unique case (state_q)
      ST_DECAY: begin
        mem_we           = 1'b1;
        mem_wdata.radius = new_rad;
        // A held report goes out once a later one is known to follow it.
        emit = (cnt_q != '0) && (cnt_q < CNT_W'(MAX_REPORTS));
      end
      ST_FLUSH: begin
        emit      = (cnt_q != '0);
        emit_last = 1'b1;
      end
      ST_ALLOC_WR: begin
        mem_we             = 1'b1;
        mem_waddr          = pick;
        mem_wdata.key      = req_q.key;
        mem_wdata.die      = req_q.die;
        mem_wdata.radius   = req_q.radius;
        mem_wdata.decay    = req_q.decay;
        mem_wdata.dark     = req_q.dark;
        mem_wdata.ent_only = req_q.ent_only;
        emit               = 1'b1;
        emit_idx           = pick;
        emit_how           = pick_how;
        emit_rad           = 20'd0;
        emit_dark          = 1'b0;
        emit_eo            = 1'b0;
        emit_last          = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign emit_ext = {5'd0, emit_idx};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      key_hit_q   <= 1'b0;
      exp_hit_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_vld_q[i] <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= emit;
      if (state_q == ST_IDLE && start_i) begin
        idx_q     <= '0;
        cnt_q     <= '0;
        key_hit_q <= 1'b0;
        exp_hit_q <= 1'b0;
      end
      if (state_q == ST_READ) rd_vld_q <= slot_vld_q[idx_q];
      if (mem_we) slot_vld_q[mem_waddr] <= 1'b1;
      if (advance && !last_idx) idx_q <= idx_q + 1'b1;
      if (state_q == ST_CHECK && req_q.cmd == CMD_ALLOC) begin
        if ((req_q.key != 16'd0) && (eff.key == req_q.key)) key_hit_q <= 1'b1;
        if (eff.die < req_q.now) exp_hit_q <= 1'b1;
      end
      if (state_q == ST_DECAY && cnt_q < CNT_W'(MAX_REPORTS)) cnt_q <= cnt_q + 1'b1;
    end
  end

  // Payload registers and the slot memory.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      req_q.cmd      <= cmd_i;
      req_q.key      <= light_key_i;
      req_q.now      <= now_ms_i;
      req_q.die      <= die_ms_i;
      req_q.elapsed  <= elapsed_ms_i;
      req_q.radius   <= start_radius_i;
      req_q.decay    <= decay_rate_i;
      req_q.dark     <= dark_in_i;
      req_q.ent_only <= entities_only_in_i;
    end
    if (state_q == ST_READ) rd_q <= slot_mem_q[idx_q];
    if (mem_we) slot_mem_q[mem_waddr] <= mem_wdata;
    if (state_q == ST_CHECK) begin
      cur_q <= eff;
      if (!key_hit_q) key_idx_q <= idx_q;
      if (!exp_hit_q) exp_idx_q <= idx_q;
    end
    if (state_q == ST_MUL1) x_q <= mul_p[35:0];
    if (state_q == ST_MUL2) begin
      quot_q <= mul_p[RECIP_SH+19:RECIP_SH];
      ge_q   <= (x_q >= 36'(thresh));
    end
    if (state_q == ST_DECAY && cnt_q < CNT_W'(MAX_REPORTS)) begin
      pend_idx_q  <= idx_q;
      pend_rad_q  <= new_rad;
      pend_dark_q <= cur_q.dark;
      pend_eo_q   <= cur_q.ent_only;
    end
    if (emit) begin
      out_slot_q <= emit_ext[4:0];
      out_how_q  <= emit_how;
      out_rad_q  <= emit_rad;
      out_dark_q <= emit_dark;
      out_eo_q   <= emit_eo;
      out_last_q <= emit_last;
    end
  end

  assign busy_o               = (state_q != ST_IDLE);
  assign res_valid_o          = res_valid_q;
  assign slot_o               = out_slot_q;
  assign how_o                = out_how_q;
  assign radius_out_o         = out_rad_q;
  assign dark_flag_o          = out_dark_q;
  assign only_entities_flag_o = out_eo_q;
  assign last_o               = out_last_q;

  // An allocate gives exactly one result, so it always closes the transaction.
  a_alloc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && how_o != HOW_TICK) |-> (last_o && radius_out_o == 20'd0))
    else $error("allocate result without last or with a radius");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_report_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_REPORTS))
    else $error("report count beyond its limit");

  // A result strobe belongs only to the emitting state (decay, flush or allocate write) just before it.
  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == ST_DECAY || $past(state_q) == ST_FLUSH
                     || $past(state_q) == ST_ALLOC_WR))
    else $error("result strobe outside an emitting state");

endmodule

@@ verif/light_report_checker.sv @@
`timescale 1ns / 1ps
// Checker for the keyed light slot allocator: it watches the command and result
// ports, keeps its own copy of the slot table and compares every result.
// Depends on kls_alloc_pkg.

module light_report_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  kls_alloc_pkg::cmd_e cmd_i,
  input  logic [15:0]         light_key_i,
  input  logic [31:0]         now_ms_i,
  input  logic [31:0]         die_ms_i,
  input  logic [15:0]         elapsed_ms_i,
  input  logic [19:0]         start_radius_i,
  input  logic [19:0]         decay_rate_i,
  input  logic                dark_in_i,
  input  logic                entities_only_in_i,
  input  logic                res_valid_i,
  input  logic [4:0]          slot_i,
  input  logic [1:0]          how_i,
  input  logic [19:0]         radius_out_i,
  input  logic                dark_flag_i,
  input  logic                only_entities_flag_i,
  input  logic                last_i,
  output int                  fail_count_o,
  output int                  outstanding_o
);
  import kls_alloc_pkg::*;

  typedef struct packed {
    logic [4:0]  slot;
    how_e        how;
    logic [19:0] radius;
    logic        dark;
    logic        ent_only;
    logic        last;
  } light_report_t;

  logic [15:0] tbl_key   [SLOTS];
  logic [31:0] tbl_die   [SLOTS];
  logic [19:0] tbl_rad   [SLOTS];
  logic [19:0] tbl_decay [SLOTS];
  logic        tbl_dark  [SLOTS];
  logic        tbl_ent   [SLOTS];

  light_report_t pending_reports[$];
  int            mismatches;

  // Allocate: key reuse first, then the lowest expired slot, else slot 0.
  task automatic place_light();
    int            pick;
    how_e          how;
    light_report_t rep;
    pick = -1;
    how  = HOW_FORCED;
    if (light_key_i != 16'd0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (pick < 0 && tbl_key[i] == light_key_i) begin
          pick = i;
          how  = HOW_KEY;
        end
      end
    end
    if (pick < 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (pick < 0 && tbl_die[i] < now_ms_i) begin
          pick = i;
          how  = HOW_EXPIRED;
        end
      end
    end
    if (pick < 0) begin
      pick = 0;
    end
    tbl_key[pick]   = light_key_i;
    tbl_die[pick]   = die_ms_i;
    tbl_rad[pick]   = start_radius_i;
    tbl_decay[pick] = decay_rate_i;
    tbl_dark[pick]  = dark_in_i;
    tbl_ent[pick]   = entities_only_in_i;
    rep.slot     = 5'(pick);
    rep.how      = how;
    rep.radius   = '0;
    rep.dark     = 1'b0;
    rep.ent_only = 1'b0;
    rep.last     = 1'b1;
    pending_reports.push_back(rep);
  endtask

  // Tick: every live slot with a nonzero radius decays and is reported.
  task automatic decay_lights();
    int            reported;
    logic [63:0]   loss;
    light_report_t rep;
    reported = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!(tbl_die[i] < now_ms_i) && tbl_rad[i] != 20'd0) begin
        loss = (64'(elapsed_ms_i) * 64'(tbl_decay[i])) / 64'd1000;
        tbl_rad[i] = (loss >= 64'(tbl_rad[i])) ? 20'd0 : 20'(64'(tbl_rad[i]) - loss);
        if (reported < MAX_REPORTS) begin
          rep.slot     = 5'(i);
          rep.how      = HOW_TICK;
          rep.radius   = tbl_rad[i];
          rep.dark     = tbl_dark[i];
          rep.ent_only = tbl_ent[i];
          rep.last     = 1'b0;
          pending_reports.push_back(rep);
          reported++;
        end
      end
    end
    if (reported > 0) begin
      pending_reports[pending_reports.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    light_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_key[i]   = '0;
        tbl_die[i]   = '0;
        tbl_rad[i]   = '0;
        tbl_decay[i] = '0;
        tbl_dark[i]  = 1'b0;
        tbl_ent[i]   = 1'b0;
      end
      pending_reports.delete();
      mismatches = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result: slot %0d how %0d radius %0d", slot_i, how_i, radius_out_i);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (slot_i != want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, slot_i);
            mismatches++;
          end
          if (how_i != want.how) begin
            $error("how: expected %0d, actual %0d", want.how, how_i);
            mismatches++;
          end
          if (radius_out_i != want.radius) begin
            $error("radius_out: expected %0d, actual %0d", want.radius, radius_out_i);
            mismatches++;
          end
          if (dark_flag_i != want.dark) begin
            $error("dark_flag: expected %0d, actual %0d", want.dark, dark_flag_i);
            mismatches++;
          end
          if (only_entities_flag_i != want.ent_only) begin
            $error("only_entities_flag: expected %0d, actual %0d", want.ent_only,
                   only_entities_flag_i);
            mismatches++;
          end
          if (last_i != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_i);
            mismatches++;
          end
        end
      end
      // A new transaction can be taken in the same cycle as the previous result.
      if (start_i && !busy_i) begin
        if (cmd_i == CMD_ALLOC) begin
          place_light();
        end else begin
          decay_lights();
        end
      end
      fail_count_o  <= mismatches;
      outstanding_o <= pending_reports.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the keyed light slot allocator testbench: clock, reset, directed and
// random commands, watchdog and verdict. Depends on kls_alloc_pkg, light_report_checker and the allocator.

module tb_top;
  import kls_alloc_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned RANDOM_ITEMS = 480;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  cmd_e        cmd_i;
  logic [15:0] light_key_i;
  logic [31:0] now_ms_i;
  logic [31:0] die_ms_i;
  logic [15:0] elapsed_ms_i;
  logic [19:0] start_radius_i;
  logic [19:0] decay_rate_i;
  logic        dark_in_i;
  logic        entities_only_in_i;
  logic        res_valid_o;
  logic [4:0]  slot_o;
  logic [1:0]  how_o;
  logic [19:0] radius_out_o;
  logic        dark_flag_o;
  logic        only_entities_flag_o;
  logic        last_o;

  int          fail_count;
  int          outstanding;
  int          idle_cycles;
  int          burst_left;
  logic [31:0] sim_now;

  keyed_light_slot_allocator u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .cmd_i                (cmd_i),
    .light_key_i          (light_key_i),
    .now_ms_i             (now_ms_i),
    .die_ms_i             (die_ms_i),
    .elapsed_ms_i         (elapsed_ms_i),
    .start_radius_i       (start_radius_i),
    .decay_rate_i         (decay_rate_i),
    .dark_in_i            (dark_in_i),
    .entities_only_in_i   (entities_only_in_i),
    .res_valid_o          (res_valid_o),
    .slot_o               (slot_o),
    .how_o                (how_o),
    .radius_out_o         (radius_out_o),
    .dark_flag_o          (dark_flag_o),
    .only_entities_flag_o (only_entities_flag_o),
    .last_o               (last_o)
  );

  light_report_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_i               (busy_o),
    .cmd_i                (cmd_i),
    .light_key_i          (light_key_i),
    .now_ms_i             (now_ms_i),
    .die_ms_i             (die_ms_i),
    .elapsed_ms_i         (elapsed_ms_i),
    .start_radius_i       (start_radius_i),
    .decay_rate_i         (decay_rate_i),
    .dark_in_i            (dark_in_i),
    .entities_only_in_i   (entities_only_in_i),
    .res_valid_i          (res_valid_o),
    .slot_i               (slot_o),
    .how_i                (how_o),
    .radius_out_i         (radius_out_o),
    .dark_flag_i          (dark_flag_o),
    .only_entities_flag_i (only_entities_flag_o),
    .last_i               (last_o),
    .fail_count_o         (fail_count),
    .outstanding_o        (outstanding)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Ends the run when neither a command nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic req_t light_req(cmd_e c, logic [15:0] k, logic [31:0] n,
                                     logic [31:0] d, logic [15:0] e, logic [19:0] r,
                                     logic [19:0] dr, logic dk, logic eo);
    req_t q;
    q.cmd      = c;
    q.key      = k;
    q.now      = n;
    q.die      = d;
    q.elapsed  = e;
    q.radius   = r;
    q.decay    = dr;
    q.dark     = dk;
    q.ent_only = eo;
    return q;
  endfunction

  // Drives one command, holds it until taken, then keeps the burst going or
  // pauses for a random gap.
  task automatic issue_request(input req_t rq);
    start_i            <= 1'b1;
    cmd_i              <= rq.cmd;
    light_key_i        <= rq.key;
    now_ms_i           <= rq.now;
    die_ms_i           <= rq.die;
    elapsed_ms_i       <= rq.elapsed;
    start_radius_i     <= rq.radius;
    decay_rate_i       <= rq.decay;
    dark_in_i          <= rq.dark;
    entities_only_in_i <= rq.ent_only;
    do @(posedge clk_i); while (busy_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(60, 180)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 30);
    end
  endtask

  function automatic logic [15:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      return 16'd0;
    end else if (sel < 8) begin
      return 16'($urandom_range(1, 8));
    end
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned scenario;
    int unsigned n_alloc;
    int unsigned sent;
    logic [15:0] step;
    logic [15:0] fill_base;

    rst_ni             = 1'b0;
    start_i            = 1'b0;
    cmd_i              = CMD_ALLOC;
    light_key_i        = '0;
    now_ms_i           = '0;
    die_ms_i           = '0;
    elapsed_ms_i       = '0;
    start_radius_i     = '0;
    decay_rate_i       = '0;
    dark_in_i          = 1'b0;
    entities_only_in_i = 1'b0;
    idle_cycles        = 0;
    burst_left         = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A tick right after reset finds no live light.
    issue_request(light_req(CMD_TICK, 16'd0, 32'd0, 32'd0, 16'd100, '0, '0, 1'b0, 1'b0));
    // Nothing expired at time 0, so the slot is forced.
    issue_request(light_req(CMD_ALLOC, 16'd0, 32'd0, 32'hFFFF_FFFF, 16'd0, 20'hFFFFF,
                            20'hFFFFF, 1'b1, 1'b1));
    issue_request(light_req(CMD_ALLOC, 16'hFFFF, 32'd1, 32'd5, 16'd0, 20'h00100, 20'd0,
                            1'b0, 1'b1));
    issue_request(light_req(CMD_ALLOC, 16'hFFFF, 32'd1, 32'hFFFF_FFFE, 16'hFFFF,
                            20'h80000, 20'd256, 1'b1, 1'b0));
    // Full decay clamps at zero; exact decay of 256 per second.
    issue_request(light_req(CMD_TICK, 16'd0, 32'd5, 32'd0, 16'd1000, '0, '0, 1'b0, 1'b0));
    // A die time equal to now still counts as alive.
    issue_request(light_req(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'd0,
                            20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1));
    issue_request(light_req(CMD_TICK, 16'd0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, '0, '0,
                            1'b0, 1'b0));
    // Key reuse wins even when that slot has expired.
    issue_request(light_req(CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 16'd0, 20'd7,
                            20'd3, 1'b0, 1'b0));
    issue_request(light_req(CMD_ALLOC, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 20'd1,
                            20'd1, 1'b1, 1'b0));
    issue_request(light_req(CMD_ALLOC, 16'd0, 32'd0, 32'd0, 16'd0, 20'd0, 20'd0,
                            1'b0, 1'b0));
    issue_request(light_req(CMD_TICK, 16'd0, 32'd0, 32'd0, 16'd999, '0, '0, 1'b0, 1'b0));
    issue_request(light_req(CMD_TICK, 16'd0, 32'd0, 32'd0, 16'hFFFF, '0, '0, 1'b0, 1'b0));
    issue_request(light_req(CMD_ALLOC, 16'd2, 32'd10, 32'd20, 16'd0, 20'hFFFFF, 20'd1000,
                            1'b0, 1'b0));
    issue_request(light_req(CMD_TICK, 16'd0, 32'd20, 32'd0, 16'd1, '0, '0, 1'b0, 1'b0));
    issue_request(light_req(CMD_TICK, 16'd0, 32'd21, 32'd0, 16'd1, '0, '0, 1'b0, 1'b0));
    issue_request(light_req(CMD_ALLOC, 16'hAAAA, 32'd21, 32'h5555_5555, 16'h5555,
                            20'h55555, 20'hAAAAA, 1'b1, 1'b0));
    issue_request(light_req(CMD_ALLOC, 16'h5555, 32'd21, 32'hAAAA_AAAA, 16'hAAAA,
                            20'hAAAAA, 20'h55555, 1'b0, 1'b1));
    issue_request(light_req(CMD_TICK, 16'hAAAA, 32'd21, 32'h5555_5555, 16'h5555,
                            20'h55555, 20'hAAAAA, 1'b1, 1'b1));

    // Random part: mostly frames of a few allocations and one tick on a running
    // clock, now and then a full table, and some unstructured noise.
    sent    = 0;
    sim_now = 32'd1000;
    while (sent < RANDOM_ITEMS) begin
      scenario = $urandom_range(0, 11);
      if (scenario == 0) begin
        fill_base = 16'($urandom);
        for (int k = 0; k <= SLOTS; k++) begin
          issue_request(light_req(CMD_ALLOC, fill_base + 16'(k), sim_now,
                                  sim_now + $urandom_range(5000, 60000), 16'($urandom),
                                  20'($urandom_range(1, 20'hFFFFF)),
                                  20'($urandom_range(0, 4096)), 1'($urandom),
                                  1'($urandom)));
        end
        step    = 16'($urandom_range(0, 200));
        sim_now = sim_now + step;
        issue_request(light_req(CMD_TICK, 16'($urandom), sim_now, 32'($urandom), step,
                                20'($urandom), 20'($urandom), 1'($urandom), 1'($urandom)));
        sent += SLOTS + 2;
      end else if (scenario == 1) begin
        issue_request(light_req(cmd_e'($urandom_range(0, 1)), 16'($urandom), 32'($urandom),
                                32'($urandom), 16'($urandom), 20'($urandom),
                                20'($urandom), 1'($urandom), 1'($urandom)));
        sent++;
      end else begin
        // Occasionally the clock jumps to a random time, which can expire much of the table.
        if (scenario == 2) begin
          sim_now = 32'($urandom);
        end
        n_alloc = $urandom_range(0, 4);
        for (int k = 0; k < n_alloc; k++) begin
          issue_request(light_req(CMD_ALLOC, pick_key(), sim_now,
                                  ($urandom_range(0, 7) == 0)
                                    ? sim_now - $urandom_range(1, 50)
                                    : sim_now + $urandom_range(0, 1500),
                                  16'($urandom),
                                  ($urandom_range(0, 9) == 0)
                                    ? 20'd0 : 20'($urandom_range(1, 20'hFFFFF)),
                                  ($urandom_range(0, 1) == 0)
                                    ? 20'($urandom_range(0, 2048)) : 20'($urandom),
                                  1'($urandom), 1'($urandom)));
        end
        step    = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
        sim_now = sim_now + step;
        issue_request(light_req(CMD_TICK, 16'($urandom), sim_now, 32'($urandom), step,
                                20'($urandom), 20'($urandom), 1'($urandom), 1'($urandom)));
        sent += n_alloc + 1;
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
